[rtl/tcb_pkg.sv]
package tcb_pkg;

    // Default sizes of the vertex set and of the triangle count per cluster
    localparam int DEF_MAX_VERTICES  = 64;
    localparam int DEF_MAX_TRIANGLES = 128;

    // Field widths
    localparam int CORNER_W   = 32;
    localparam int START_W    = 32;
    localparam int INDICES_W  = 9;
    localparam int VERTICES_W = 7;
    localparam int FAULT_W    = 2;
    localparam int VLIM_W     = 7;
    localparam int TLIM_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 3 * CORNER_W;
    localparam int M_DATA_W   = START_W + INDICES_W + VERTICES_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MESH_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE_LIMIT    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [VLIM_W-1:0] VLIM_RESET = 7'd64;
    localparam logic [TLIM_W-1:0] TLIM_RESET = 8'd128;

    // Fault codes carried in tuser
    localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_RANGE    = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_OVERFLOW = 2'd2;

    // Controller -> datapath
    typedef struct packed {
        logic       load;      // capture the input triangle
        logic       scan;      // compare one corner against the vertex set
        logic [1:0] scan_idx;  // corner being scanned
        logic       commit;    // apply the triangle, emit fault or close record
        logic       flush;     // emit the open cluster at end of mesh
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic emit_now;      // commit produces a record
        logic flush_needed;  // an end-of-mesh flush follows the commit
        logic out_free;      // output register can take a record this cycle
    } t_status;

endpackage

[rtl/tcb_ctrl.sv]
module tcb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tcb_pkg::t_status i_status,
    output tcb_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    localparam logic [1:0] LAST_CORNER = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_scan_cnt, n_scan_cnt;

    always_comb begin
        n_state      = r_state;
        n_scan_cnt   = r_scan_cnt;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.scan_idx = r_scan_cnt;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_scan_cnt = 2'd0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_scan_cnt == LAST_CORNER) begin
                    n_state = S_COMMIT;
                end else begin
                    n_scan_cnt = r_scan_cnt + 2'd1;
                end
            end
            S_COMMIT: begin
                // wait for room only when a record goes out
                if (!i_status.emit_now || i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = i_status.flush_needed ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_cnt <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_scan_cnt <= n_scan_cnt;
        end
    end

endmodule

[rtl/tcb_datapath.sv]
module tcb_datapath #(
    parameter int MAX_VERTICES  = tcb_pkg::DEF_MAX_VERTICES,
    parameter int MAX_TRIANGLES = tcb_pkg::DEF_MAX_TRIANGLES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input triangle
    input  logic [tcb_pkg::S_DATA_W-1:0]        i_in_data,
    input  logic                                i_in_end,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [tcb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tcb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // control
    input  tcb_pkg::t_cmd                       i_cmd,
    output tcb_pkg::t_status                    o_status,
    // result
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tcb_pkg::M_DATA_W-1:0]        o_out_data,
    output logic [tcb_pkg::FAULT_W-1:0]         o_out_fault,
    output logic                                o_out_final
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int IW = $clog2(3 * MAX_TRIANGLES + 1);
    localparam int TW = $clog2(MAX_TRIANGLES + 1);
    localparam int SW = tcb_pkg::START_W;
    localparam int VW = tcb_pkg::CORNER_W;

    localparam logic [SW:0] STREAM_MAX = {1'b0, {SW{1'b1}}};

    // configuration registers
    logic [VW-1:0]               r_mvc;
    logic [tcb_pkg::VLIM_W-1:0]  r_vlim_cfg;
    logic [tcb_pkg::TLIM_W-1:0]  r_tlim_cfg;

    // current triangle and scan results
    logic [VW-1:0] r_corner [3];
    logic          r_end;
    logic [2:0]    r_hit;
    logic [2:0]    r_dup;
    logic [2:0]    r_oor;

    // open cluster
    logic [VW-1:0] r_list [MAX_VERTICES];
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_open_idx;
    logic [TW-1:0] r_tri;
    logic [SW-1:0] r_start;

    // output register
    logic                              r_out_valid;
    logic [SW-1:0]                     r_out_start;
    logic [tcb_pkg::INDICES_W-1:0]     r_out_idx;
    logic [tcb_pkg::VERTICES_W-1:0]    r_out_vert;
    logic [tcb_pkg::FAULT_W-1:0]       r_out_fault;
    logic                              r_out_final;

    // scan
    logic [VW-1:0]           scan_corner;
    logic                    scan_hit;
    logic                    scan_dup;
    logic [MAX_VERTICES-1:0] entry_hit;

    always_comb begin
        case (i_cmd.scan_idx)
            2'd0:    scan_corner = r_corner[0];
            2'd1:    scan_corner = r_corner[1];
            default: scan_corner = r_corner[2];
        endcase
        case (i_cmd.scan_idx)
            2'd0:    scan_dup = 1'b0;
            2'd1:    scan_dup = (r_corner[0] == r_corner[1]);
            default: scan_dup = (r_corner[0] == r_corner[2]) ||
                                (r_corner[1] == r_corner[2]);
        endcase
    end

    // whole vertex set compared at once, only the filled part counts
    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            entry_hit[i] = (CW'(i) < r_count) && (r_list[i] == scan_corner);
        end
    end
    assign scan_hit = |entry_hit;

    // commit decision
    logic [SW:0]   pos;
    logic          fault_ovf;
    logic          fault_rng;
    logic          fault_any;
    logic [2:0]    is_new;
    logic [1:0]    added;
    logic [CW-1:0] vlim;
    logic [TW-1:0] tlim;
    logic [31:0]   vcfg_w;
    logic [31:0]   tcfg_w;
    logic          close_c;
    logic [2:0]    ins;
    logic [CW-1:0] base;
    logic [CW-1:0] slot [3];
    logic          open_after;

    assign pos       = {1'b0, r_start} + (SW+1)'(r_open_idx);
    assign fault_ovf = (pos + (SW+1)'(3)) > STREAM_MAX;
    assign fault_rng = |r_oor;
    assign fault_any = fault_ovf || fault_rng;
    assign is_new    = ~r_hit & ~r_dup;
    assign added     = 2'(is_new[0]) + 2'(is_new[1]) + 2'(is_new[2]);
    assign vcfg_w    = 32'(r_vlim_cfg);
    assign tcfg_w    = 32'(r_tlim_cfg);

    always_comb begin
        if (vcfg_w < 32'd3) begin
            vlim = CW'(3);
        end else if (vcfg_w > 32'(MAX_VERTICES)) begin
            vlim = CW'(MAX_VERTICES);
        end else begin
            vlim = CW'(vcfg_w);
        end
        if (tcfg_w < 32'd1) begin
            tlim = TW'(1);
        end else if (tcfg_w > 32'(MAX_TRIANGLES)) begin
            tlim = TW'(MAX_TRIANGLES);
        end else begin
            tlim = TW'(tcfg_w);
        end
    end

    assign close_c = (r_open_idx != '0) &&
                     ((r_tri >= tlim) ||
                      (({1'b0, r_count} + (CW+1)'(added)) > {1'b0, vlim}));

    // after a close the set is empty: only in-triangle duplicates are skipped
    assign ins     = close_c ? ~r_dup : is_new;
    assign base    = close_c ? '0 : r_count;
    assign slot[0] = base;
    assign slot[1] = base + CW'(ins[0]);
    assign slot[2] = base + CW'(ins[0]) + CW'(ins[1]);
    assign n_count = base + CW'(ins[0]) + CW'(ins[1]) + CW'(ins[2]);

    assign open_after = !fault_any || (r_open_idx != '0);

    assign o_status.emit_now     = fault_any || close_c;
    assign o_status.flush_needed = r_end && open_after;
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvc      <= '0;
            r_vlim_cfg <= tcb_pkg::VLIM_RESET;
            r_tlim_cfg <= tcb_pkg::TLIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcb_pkg::REG_MESH_VERTEX_COUNT: r_mvc      <= i_cfg_data;
                tcb_pkg::REG_VERTEX_LIMIT:
                    r_vlim_cfg <= i_cfg_data[tcb_pkg::VLIM_W-1:0];
                tcb_pkg::REG_TRIANGLE_LIMIT:
                    r_tlim_cfg <= i_cfg_data[tcb_pkg::TLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // triangle capture and scan results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_corner[0] <= i_in_data[VW-1:0];
            r_corner[1] <= i_in_data[2*VW-1:VW];
            r_corner[2] <= i_in_data[3*VW-1:2*VW];
            r_end       <= i_in_end;
        end
        if (i_cmd.scan) begin
            case (i_cmd.scan_idx)
                2'd0: begin
                    r_hit[0] <= scan_hit;
                    r_dup[0] <= scan_dup;
                    r_oor[0] <= (scan_corner >= r_mvc);
                end
                2'd1: begin
                    r_hit[1] <= scan_hit;
                    r_dup[1] <= scan_dup;
                    r_oor[1] <= (scan_corner >= r_mvc);
                end
                default: begin
                    r_hit[2] <= scan_hit;
                    r_dup[2] <= scan_dup;
                    r_oor[2] <= (scan_corner >= r_mvc);
                end
            endcase
        end
    end

    // vertex set, up to three entries written on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !fault_any) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                if (ins[0] && slot[0] == CW'(i)) begin
                    r_list[i] <= r_corner[0];
                end else if (ins[1] && slot[1] == CW'(i)) begin
                    r_list[i] <= r_corner[1];
                end else if (ins[2] && slot[2] == CW'(i)) begin
                    r_list[i] <= r_corner[2];
                end
            end
        end
    end

    // open cluster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_open_idx <= '0;
            r_tri      <= '0;
            r_start    <= '0;
        end else if (i_cmd.commit && !fault_any) begin
            r_count <= n_count;
            if (close_c) begin
                r_start    <= r_start + SW'(r_open_idx);
                r_open_idx <= IW'(3);
                r_tri      <= TW'(1);
            end else begin
                r_open_idx <= r_open_idx + IW'(3);
                r_tri      <= r_tri + TW'(1);
            end
        end else if (i_cmd.flush) begin
            r_start    <= r_start + SW'(r_open_idx);
            r_open_idx <= '0;
            r_tri      <= '0;
            r_count    <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.commit && o_status.emit_now) || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && fault_any) begin
            r_out_start <= pos[SW-1:0];
            r_out_idx   <= '0;
            r_out_vert  <= '0;
            r_out_fault <= fault_ovf ? tcb_pkg::FAULT_OVERFLOW : tcb_pkg::FAULT_RANGE;
            r_out_final <= !o_status.flush_needed;
        end else if ((i_cmd.commit && close_c) || i_cmd.flush) begin
            r_out_start <= r_start;
            r_out_idx   <= tcb_pkg::INDICES_W'(r_open_idx);
            r_out_vert  <= tcb_pkg::VERTICES_W'(r_count);
            r_out_fault <= tcb_pkg::FAULT_NONE;
            r_out_final <= i_cmd.flush || !o_status.flush_needed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_vert, r_out_idx, r_out_start};
    assign o_out_fault = r_out_fault;
    assign o_out_final = r_out_final;

endmodule

[rtl/triangle_cluster_builder.sv]
// Triangle cluster builder: groups a triangle list into clusters in stream order.
// Slave stream: one transaction per triangle, tdata holds corner_a/b/c, tlast
// marks the last triangle of the mesh (the open cluster is flushed after it).
// Master stream: one transaction per record; tdata holds start/indices/vertex
// count, tuser the fault code, tlast the last record caused by a triangle.
// A triangle gives zero, one or two records (close before it, flush after it).
// Config channel: index 0 mesh vertex count, 1 vertex limit, 2 triangle limit;
// always ready, to be written only while no triangle is in flight.
// Sequence: a triangle is accepted, its corners are scanned in turn, and it is
// committed before the next one can be accepted; an end-of-mesh flush adds a
// flush step. The pace is set by the single comparator bank that checks one
// corner per cycle against the whole vertex set of the open cluster.
// A close or fault record is written into the output register at commit, a
// flush record at the flush step that follows it.
// A record sits in a one-entry output register; the next triangle is taken
// while it waits, and the block only holds in commit or flush if a new record
// must be written while the receiver still stalls.
// Reset clears the cluster counters, stream position and config to defaults.
module triangle_cluster_builder #(
    parameter int MAX_VERTICES  = tcb_pkg::DEF_MAX_VERTICES,
    parameter int MAX_TRIANGLES = tcb_pkg::DEF_MAX_TRIANGLES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // triangle input
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [31:0] corner_a, [63:32] corner_b, [95:64] corner_c
    input  logic [tcb_pkg::S_DATA_W-1:0]     i_s_axis_tdata,
    input  logic                             i_s_axis_tlast,   // end_of_mesh
    // cluster records
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [31:0] cluster_start, [40:32] cluster_indices, [47:41] cluster_vertices
    output logic [tcb_pkg::M_DATA_W-1:0]     o_m_axis_tdata,
    output logic [tcb_pkg::FAULT_W-1:0]      o_m_axis_tuser,   // [1:0] fault
    output logic                             o_m_axis_tlast,   // final_record
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tcb_pkg::t_cmd    cmd;
    tcb_pkg::t_status status;
    logic             in_ready;

    // registers are plain flops, a write always completes
    assign o_cfg_ready = 1'b1;

    tcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign o_s_axis_tready = in_ready;

    tcb_datapath #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .i_in_end    (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_fault (o_m_axis_tuser),
        .o_out_final (o_m_axis_tlast)
    );

endmodule
